/* rtl/rhpm_pkg.sv */
// Shared types and constants for the rolling hash pattern matcher.
// No dependencies; imported by the cell, the modular reducer and the top level.
`timescale 1ns / 1ps

package rhpm_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned HASH_W      = 16;
  localparam int unsigned MAG_W       = BYTE_W + HASH_W;
  localparam int unsigned CNT_W       = 32;
  localparam logic [HASH_W-1:0] DEFAULT_MOD = 16'd101;

  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_PATTERN = 2'd1;
  localparam logic [1:0] MODE_TEXT    = 2'd2;

  // shift strobes for the cell row
  typedef struct packed {
    logic pat_shift;
    logic txt_shift;
  } rhpm_shift_t;

  // one job for the modular reducer: (+/-mag, then tail byte) mod q
  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [BYTE_W-1:0] tail;
  } rhpm_red_req_t;

endpackage

/* rtl/rhpm_cell.sv */
// One cell of the window row: holds a pattern byte and a text byte and
// passes both to its neighbor on a shift. Depends on rhpm_pkg.
`timescale 1ns / 1ps

module rhpm_cell import rhpm_pkg::*; (
  input  logic              clk_i,
  input  rhpm_shift_t       ctl_i,
  input  logic              en_i,
  input  logic [BYTE_W-1:0] pat_i,
  input  logic [BYTE_W-1:0] txt_i,
  output logic [BYTE_W-1:0] pat_o,
  output logic [BYTE_W-1:0] txt_o,
  output logic              ok_o
);

  logic [BYTE_W-1:0] pat_q;
  logic [BYTE_W-1:0] txt_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pat_shift) begin
      pat_q <= pat_i;
    end
    if (ctl_i.txt_shift) begin
      txt_q <= txt_i;
    end
  end

  assign pat_o = pat_q;
  assign txt_o = txt_q;
  // cells past the pattern length do not take part
  assign ok_o  = !en_i || (pat_q == txt_q);

endmodule

/* rtl/rhpm_modred.sv */
// Serial modular reducer, two bits per cycle, restoring shift-subtract.
// Computes ((+/-mag) mod q) * 256 + tail, mod q. Depends on rhpm_pkg.
`timescale 1ns / 1ps

module rhpm_modred import rhpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rhpm_red_req_t     req_i,
  input  logic [HASH_W-1:0] q_i,
  output logic              done_o,
  output logic [HASH_W-1:0] res_o
);

  localparam int unsigned SH_W      = MAG_W + BYTE_W;
  localparam int unsigned MAG_STEPS = MAG_W / 2;
  localparam int unsigned FIX_STEP  = MAG_STEPS;
  localparam int unsigned LAST_STEP = MAG_STEPS + BYTE_W / 2;
  localparam int unsigned STEP_W    = $clog2(LAST_STEP + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [SH_W-1:0]   sh_q;
  logic [HASH_W-1:0] r_q;
  logic              neg_q;

  function automatic logic [HASH_W-1:0] red2(input logic [HASH_W-1:0] r,
                                             input logic [1:0] bits,
                                             input logic [HASH_W-1:0] q);
    logic [HASH_W:0]   x;
    logic [HASH_W-1:0] acc;
    acc = r;
    for (int i = 1; i >= 0; i--) begin
      x = {acc, bits[i]};
      if (x >= {1'b0, q}) begin
        x = x - {1'b0, q};
      end
      acc = x[HASH_W-1:0];
    end
    return acc;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        sh_q   <= {req_i.mag, req_i.tail};
        r_q    <= '0;
        neg_q  <= req_i.neg;
      end else if (busy_q) begin
        if (step_q == STEP_W'(FIX_STEP)) begin
          // negative operand: fold the residue back into [0, q)
          r_q <= (neg_q && (r_q != '0)) ? (q_i - r_q) : r_q;
        end else begin
          r_q  <= red2(r_q, sh_q[SH_W-1 -: 2], q_i);
          sh_q <= sh_q << 2;
        end
        if (step_q == STEP_W'(LAST_STEP)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

/* rtl/rolling_hash_pattern_matcher.sv */
// Rabin-Karp matcher over a byte stream: row of cells, serial mod-q reducer.
// Text byte with a pattern loaded: ST_MUL, ST_RED_WH, ST_CMP, then ST_OUT; the next beat waits until ST_OUT is done.
// Pattern byte: two runs of the reducer (one for the first byte), for the pattern hash and the leading power.
// Clear, unused mode, text with no pattern, pattern byte when full: straight to ST_OUT.
// The reducer works two bits a cycle, plus a sign fix step in each run.
// Async active-low reset: modulus 101, empty pattern, leading power 1, no result pending.
`timescale 1ns / 1ps

module rolling_hash_pattern_matcher import rhpm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [HASH_W-1:0] cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // data_byte
  input  logic [1:0]        s_axis_tuser,   // mode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,   // start_index[31:0], window_hash[47:32]
  output logic [1:0]        m_axis_tuser    // hash_hit[0], match[1]
);

  localparam int unsigned PLW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED_WH,
    ST_RED_PH,
    ST_RED_LP,
    ST_CMP,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [HASH_W-1:0] mod_q;
  logic [PLW-1:0]    plen_q;
  logic [HASH_W-1:0] ph_q;
  logic [HASH_W-1:0] lp_q;
  logic [HASH_W-1:0] wh_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [BYTE_W-1:0] byte_q;
  logic [MAG_W-1:0]  prod_q;
  logic              red_start_q;
  rhpm_red_req_t     red_req_q;
  logic              res_hit_q;
  logic              res_match_q;
  logic [CNT_W-1:0]  res_start_q;
  logic [HASH_W-1:0] res_wh_q;
  logic              out_valid_q;
  logic              out_hit_q;
  logic              out_match_q;
  logic [CNT_W-1:0]  out_start_q;
  logic [HASH_W-1:0] out_wh_q;

  logic              s_accept;
  logic              pat_room;
  logic              win_full;
  logic              all_eq;
  logic [HASH_W-1:0] q_eff;
  logic [IW-1:0]     drop_idx;
  logic [BYTE_W-1:0] drop_byte;
  logic [MAG_W:0]    z;
  logic [MAG_W:0]    z_neg;
  logic              red_done;
  logic [HASH_W-1:0] red_res;
  rhpm_shift_t       ctl;

  logic [BYTE_W-1:0]      pat_w [MAX_PATTERN];
  logic [BYTE_W-1:0]      txt_w [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok_w;
  logic [MAX_PATTERN-1:0] en_w;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign pat_room      = plen_q < PLW'(MAX_PATTERN);
  assign win_full      = cnt_q >= CNT_W'(plen_q);
  assign q_eff         = (mod_q == '0) ? HASH_W'(1) : mod_q;
  assign all_eq        = &ok_w;
  assign drop_idx      = IW'(plen_q - PLW'(1));
  assign drop_byte     = txt_w[drop_idx];
  assign z             = (MAG_W + 1)'(wh_q) - (MAG_W + 1)'(prod_q);
  assign z_neg         = (MAG_W + 1)'(0) - z;

  assign ctl.pat_shift = s_accept && (s_axis_tuser == MODE_PATTERN) && pat_room;
  assign ctl.txt_shift = s_accept && (s_axis_tuser == MODE_TEXT);

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [BYTE_W-1:0] pat_in;
    logic [BYTE_W-1:0] txt_in;
    if (k == 0) begin : g_head
      assign pat_in = s_axis_tdata;
      assign txt_in = s_axis_tdata;
    end else begin : g_link
      assign pat_in = pat_w[k-1];
      assign txt_in = txt_w[k-1];
    end
    assign en_w[k] = PLW'(k) < plen_q;

    rhpm_cell u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .en_i  (en_w[k]),
      .pat_i (pat_in),
      .txt_i (txt_in),
      .pat_o (pat_w[k]),
      .txt_o (txt_w[k]),
      .ok_o  (ok_w[k])
    );
  end

  rhpm_modred u_modred (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start_q),
    .req_i   (red_req_q),
    .q_i     (q_eff),
    .done_o  (red_done),
    .res_o   (red_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mod_q       <= DEFAULT_MOD;
      plen_q      <= '0;
      ph_q        <= '0;
      lp_q        <= HASH_W'(1);
      wh_q        <= '0;
      cnt_q       <= '0;
      red_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      red_start_q <= 1'b0;
      if (cfg_valid_i) begin
        mod_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            byte_q      <= s_axis_tdata;
            res_hit_q   <= 1'b0;
            res_match_q <= 1'b0;
            res_start_q <= '0;
            res_wh_q    <= '0;
            state_q     <= ST_OUT;
            case (s_axis_tuser)
              MODE_CLEAR: begin
                plen_q <= '0;
                ph_q   <= '0;
                lp_q   <= HASH_W'(1);
                wh_q   <= '0;
                cnt_q  <= '0;
              end
              MODE_PATTERN: begin
                wh_q  <= '0;
                cnt_q <= '0;
                if (pat_room) begin
                  red_start_q <= 1'b1;
                  red_req_q   <= '{neg: 1'b0, mag: MAG_W'(ph_q), tail: s_axis_tdata};
                  state_q     <= ST_RED_PH;
                end
              end
              MODE_TEXT: begin
                if (cnt_q != '1) begin
                  cnt_q <= cnt_q + 1'b1;
                end
                if (plen_q == '0) begin
                  res_wh_q <= wh_q;
                end else begin
                  prod_q  <= win_full ? (MAG_W'(drop_byte) * MAG_W'(lp_q)) : '0;
                  state_q <= ST_MUL;
                end
              end
              default: begin
                res_wh_q <= wh_q;
              end
            endcase
          end
        end
        ST_MUL: begin
          red_start_q <= 1'b1;
          red_req_q   <= '{neg: z[MAG_W],
                           mag: z[MAG_W] ? z_neg[MAG_W-1:0] : z[MAG_W-1:0],
                           tail: byte_q};
          state_q     <= ST_RED_WH;
        end
        ST_RED_WH: begin
          if (red_done) begin
            wh_q    <= red_res;
            state_q <= ST_CMP;
          end
        end
        ST_RED_PH: begin
          if (red_done) begin
            ph_q <= red_res;
            if (plen_q != '0) begin
              red_start_q <= 1'b1;
              red_req_q   <= '{neg: 1'b0, mag: MAG_W'(lp_q), tail: '0};
              state_q     <= ST_RED_LP;
            end else begin
              plen_q  <= plen_q + 1'b1;
              state_q <= ST_OUT;
            end
          end
        end
        ST_RED_LP: begin
          if (red_done) begin
            lp_q    <= red_res;
            plen_q  <= plen_q + 1'b1;
            state_q <= ST_OUT;
          end
        end
        ST_CMP: begin
          res_hit_q   <= win_full && (wh_q == ph_q);
          res_match_q <= win_full && (wh_q == ph_q) && all_eq;
          res_start_q <= (win_full && (wh_q == ph_q) && all_eq) ?
                         (cnt_q - CNT_W'(plen_q)) : '0;
          res_wh_q    <= wh_q;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= res_hit_q;
            out_match_q <= res_match_q;
            out_start_q <= res_start_q;
            out_wh_q    <= res_wh_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_wh_q, out_start_q};
  assign m_axis_tuser  = {out_match_q, out_hit_q};

endmodule
